// ----- sv/dlcrq_pkg.sv -----
// ----------------------------------------------------------------------------
// dlcrq_pkg
// Shared types, constants and helpers for the dual line command ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dlcrq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PAYLOAD = 64;
    localparam int NUM_LINES   = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int SLOT_W      = PTR_W + 1;
    localparam int REC_DEPTH   = 2 ** SLOT_W;
    localparam int OFF_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PAY_DEPTH   = REC_DEPTH * MAX_PAYLOAD;
    localparam int PAY_AW      = $clog2(PAY_DEPTH);
    localparam int SIZE_W      = 7;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // Command codes
    localparam logic [1:0] CMD_HDR   = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BIG     = 3'd2;
    localparam logic [2:0] ST_BADLINE = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_SEQ     = 3'd5;

    // Input transaction
    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         line;
        logic [15:0]        client_id;
        logic signed [15:0] packet_command;
        logic [7:0]         payload_size;
        logic signed [31:0] exec_word;
        logic [7:0]         payload_byte;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        out_client_id;
        logic signed [15:0] out_command;
        logic [6:0]         out_size;
        logic signed [31:0] out_exec_word;
        logic [7:0]         out_byte;
        logic               last;
    } out_item_t;

    // Stored record header
    typedef struct packed {
        logic [15:0]        client;
        logic signed [15:0] command;
        logic [SIZE_W-1:0]  size;
        logic signed [31:0] exec;
    } rec_t;

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_STATUS,
        OP_HDR,
        OP_BYTE,
        OP_FETCH
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
        rec_t              hdr;
        logic [7:0]        pay_byte;
    } op_t;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

    // Ring pointer increment with wrap
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dual_line_command_ring_queue_unit.sv -----
// An add or payload result passes the op queue and the result register; a fetch's first
// result also passes the record and payload read registers, then one result per cycle
// follows while the output is not stalled. The front end takes one transaction per cycle
// into a 4-entry op queue while it is not full; the back end retires one add/payload op
// per cycle while the output is not stalled, and streams a fetch one byte per result.
// Reset: asynchronous, clears ring pointers, fill state and queues; memories are not cleared.
// ----------------------------------------------------------------------------
// dual_line_command_ring_queue_unit
// Two ring queues of command records with a decoupled front end (checks and
// pointer updates) and back end (memory writes and record streaming).
// ----------------------------------------------------------------------------
`default_nettype none

module dual_line_command_ring_queue_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire dlcrq_pkg::in_item_t  cmd_item,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output dlcrq_pkg::out_item_t      res_item
);

    dlcrq_pkg::op_t push_op;
    dlcrq_pkg::op_t head_op;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // Front end: classify and update pointers
    dlcrq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    // Op queue
    dlcrq_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back end: memories and result stream
    dlcrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (head_op),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire

// ----- sv/dlcrq_front.sv -----
// ----------------------------------------------------------------------------
// dlcrq_front
// Accepts command transactions, checks them against the ring pointers and the
// fill state, updates the pointers and issues one work op per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcrq_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire dlcrq_pkg::in_item_t cmd_item,
    input  wire logic                q_full,
    output logic                     q_push,
    output dlcrq_pkg::op_t           q_op
);

    logic [dlcrq_pkg::PTR_W-1:0]  head_reg [dlcrq_pkg::NUM_LINES];
    logic [dlcrq_pkg::PTR_W-1:0]  tail_reg [dlcrq_pkg::NUM_LINES];
    logic [dlcrq_pkg::PTR_W-1:0]  head_next;
    logic [dlcrq_pkg::PTR_W-1:0]  tail_next;
    logic                         head_we;
    logic                         tail_we;
    logic                         fill_active_reg, fill_active_next;
    logic                         fill_line_reg, fill_line_next;
    logic [dlcrq_pkg::SIZE_W-1:0] fill_count_reg, fill_count_next;
    logic [dlcrq_pkg::SIZE_W-1:0] fill_size_reg, fill_size_next;
    logic                         sel_line;
    logic [dlcrq_pkg::PTR_W-1:0]  sel_head;
    logic [dlcrq_pkg::PTR_W-1:0]  sel_tail;
    logic [dlcrq_pkg::SIZE_W-1:0] count_inc;
    logic                         accept;

    assign accept    = cmd_valid && !q_full;
    assign cmd_stall = q_full;
    assign q_push    = accept;

    // Payload bytes go to the line being filled; others use the line field
    assign sel_line  = (cmd_item.cmd == dlcrq_pkg::CMD_BYTE) ? fill_line_reg
                                                              : cmd_item.line[0];
    assign sel_head  = head_reg[sel_line];
    assign sel_tail  = tail_reg[sel_line];
    assign count_inc = fill_count_reg + 1'b1;

    // Classify the transaction and work out pointer / fill updates
    always_comb
    begin
        q_op             = '0;
        q_op.kind        = dlcrq_pkg::OP_STATUS;
        q_op.status      = dlcrq_pkg::ST_SEQ;
        head_next        = dlcrq_pkg::next_ptr(sel_head);
        tail_next        = dlcrq_pkg::next_ptr(sel_tail);
        head_we          = 1'b0;
        tail_we          = 1'b0;
        fill_active_next = fill_active_reg;
        fill_line_next   = fill_line_reg;
        fill_count_next  = fill_count_reg;
        fill_size_next   = fill_size_reg;

        case (cmd_item.cmd)
            dlcrq_pkg::CMD_HDR:
            begin
                if (fill_active_reg)
                begin
                    q_op.status = dlcrq_pkg::ST_SEQ;
                end
                else if (cmd_item.line[1])
                begin
                    q_op.status = dlcrq_pkg::ST_BADLINE;
                end
                else if (cmd_item.payload_size > 8'(dlcrq_pkg::MAX_PAYLOAD))
                begin
                    q_op.status = dlcrq_pkg::ST_BIG;
                end
                else if (sel_head == tail_next)
                begin
                    q_op.status = dlcrq_pkg::ST_FULL;
                end
                else
                begin
                    q_op.kind        = dlcrq_pkg::OP_HDR;
                    q_op.status      = dlcrq_pkg::ST_OK;
                    q_op.slot        = {sel_line, sel_tail};
                    q_op.hdr.client  = cmd_item.client_id;
                    q_op.hdr.command = cmd_item.packet_command;
                    q_op.hdr.size    = cmd_item.payload_size[dlcrq_pkg::SIZE_W-1:0];
                    q_op.hdr.exec    = cmd_item.exec_word;
                    if (cmd_item.payload_size == 8'd0)
                    begin
                        tail_we = 1'b1;
                    end
                    else
                    begin
                        fill_active_next = 1'b1;
                        fill_line_next   = sel_line;
                        fill_count_next  = '0;
                        fill_size_next   = cmd_item.payload_size[dlcrq_pkg::SIZE_W-1:0];
                    end
                end
            end

            dlcrq_pkg::CMD_BYTE:
            begin
                if (fill_active_reg)
                begin
                    q_op.kind     = dlcrq_pkg::OP_BYTE;
                    q_op.status   = dlcrq_pkg::ST_OK;
                    q_op.slot     = {sel_line, sel_tail};
                    q_op.off      = fill_count_reg[dlcrq_pkg::OFF_W-1:0];
                    q_op.pay_byte = cmd_item.payload_byte;
                    if (count_inc >= fill_size_reg)
                    begin
                        tail_we          = 1'b1;
                        fill_active_next = 1'b0;
                        fill_count_next  = '0;
                    end
                    else
                    begin
                        fill_count_next = count_inc;
                    end
                end
            end

            dlcrq_pkg::CMD_FETCH:
            begin
                if (cmd_item.line[1])
                begin
                    q_op.status = dlcrq_pkg::ST_BADLINE;
                end
                else if (sel_head == sel_tail)
                begin
                    q_op.status = dlcrq_pkg::ST_EMPTY;
                end
                else
                begin
                    q_op.kind   = dlcrq_pkg::OP_FETCH;
                    q_op.status = dlcrq_pkg::ST_OK;
                    q_op.slot   = {sel_line, sel_head};
                    head_we     = 1'b1;
                end
            end

            default:
            begin
                q_op.status = dlcrq_pkg::ST_SEQ;
            end
        endcase
    end

    // Pointer and fill state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dlcrq_pkg::NUM_LINES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            fill_active_reg <= 1'b0;
            fill_line_reg   <= 1'b0;
            fill_count_reg  <= '0;
            fill_size_reg   <= '0;
        end
        else if (accept)
        begin
            if (head_we)
            begin
                head_reg[sel_line] <= head_next;
            end
            if (tail_we)
            begin
                tail_reg[sel_line] <= tail_next;
            end
            fill_active_reg <= fill_active_next;
            fill_line_reg   <= fill_line_next;
            fill_count_reg  <= fill_count_next;
            fill_size_reg   <= fill_size_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dlcrq_fifo.sv -----
// ----------------------------------------------------------------------------
// dlcrq_fifo
// Short op queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcrq_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dlcrq_pkg::op_t push_op,
    input  wire logic           pop,
    output dlcrq_pkg::op_t      head_op,
    output logic                full,
    output logic                empty
);

    dlcrq_pkg::op_t                  entry_reg [dlcrq_pkg::FIFO_DEPTH];
    logic [dlcrq_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dlcrq_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dlcrq_pkg::FIFO_AW:0]     count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (dlcrq_pkg::FIFO_AW + 1)'(dlcrq_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dlcrq_back.sv -----
// ----------------------------------------------------------------------------
// dlcrq_back
// Executes queued ops: writes headers and payload bytes into the record and
// payload memories, and streams fetched records out one byte per result.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcrq_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dlcrq_pkg::op_t op,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                res_valid,
    input  wire logic           res_stall,
    output dlcrq_pkg::out_item_t res_item
);

    // Storage
    dlcrq_pkg::rec_t                rec_mem [dlcrq_pkg::REC_DEPTH];
    logic [7:0]                     pay_mem [dlcrq_pkg::PAY_DEPTH];

    dlcrq_pkg::back_state_t         state_reg, state_next;
    logic [dlcrq_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [dlcrq_pkg::SIZE_W-1:0]   cnt_reg, cnt_next;
    dlcrq_pkg::rec_t                rec_rd_reg;
    logic [7:0]                     pay_rd_reg;
    logic                           out_valid_reg;
    dlcrq_pkg::out_item_t           out_reg;
    dlcrq_pkg::out_item_t           out_next;

    logic                           out_free;
    logic                           load;
    logic                           rd_en;
    logic [dlcrq_pkg::SLOT_W-1:0]   rd_slot;
    logic [dlcrq_pkg::OFF_W-1:0]    rd_off;
    logic [dlcrq_pkg::PAY_AW-1:0]   rd_addr;
    logic [dlcrq_pkg::PAY_AW-1:0]   wr_addr;
    logic                           hdr_we;
    logic                           pay_we;
    logic [dlcrq_pkg::SIZE_W-1:0]   cnt_inc;
    logic                           stream_last;

    assign out_free    = !out_valid_reg || !res_stall;
    assign cnt_inc     = cnt_reg + 1'b1;
    assign stream_last = (rec_rd_reg.size == '0) || (cnt_inc == rec_rd_reg.size);
    assign rd_addr     = dlcrq_pkg::PAY_AW'(rd_slot) * dlcrq_pkg::PAY_AW'(dlcrq_pkg::MAX_PAYLOAD)
                         + dlcrq_pkg::PAY_AW'(rd_off);
    assign wr_addr     = dlcrq_pkg::PAY_AW'(op.slot) * dlcrq_pkg::PAY_AW'(dlcrq_pkg::MAX_PAYLOAD)
                         + dlcrq_pkg::PAY_AW'(op.off);
    assign res_valid   = out_valid_reg;
    assign res_item    = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlcrq_pkg::BK_IDLE:
            begin
                if (!q_empty && out_free && op.kind == dlcrq_pkg::OP_FETCH)
                begin
                    state_next = dlcrq_pkg::BK_STREAM;
                end
            end
            dlcrq_pkg::BK_STREAM:
            begin
                if (out_free && stream_last)
                begin
                    state_next = dlcrq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dlcrq_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        load      = 1'b0;
        rd_en     = 1'b0;
        rd_slot   = slot_reg;
        rd_off    = '0;
        hdr_we    = 1'b0;
        pay_we    = 1'b0;
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        out_next  = '0;
        out_next.last = 1'b1;

        case (state_reg)
            dlcrq_pkg::BK_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (op.kind)
                        dlcrq_pkg::OP_FETCH:
                        begin
                            rd_en     = 1'b1;
                            rd_slot   = op.slot;
                            slot_next = op.slot;
                            cnt_next  = '0;
                        end
                        dlcrq_pkg::OP_HDR:
                        begin
                            hdr_we          = 1'b1;
                            load            = 1'b1;
                            out_next.status = op.status;
                        end
                        dlcrq_pkg::OP_BYTE:
                        begin
                            pay_we          = 1'b1;
                            load            = 1'b1;
                            out_next.status = op.status;
                        end
                        default:
                        begin
                            load            = 1'b1;
                            out_next.status = op.status;
                        end
                    endcase
                end
            end

            dlcrq_pkg::BK_STREAM:
            begin
                if (out_free)
                begin
                    load                   = 1'b1;
                    out_next.status        = dlcrq_pkg::ST_OK;
                    out_next.out_client_id = rec_rd_reg.client;
                    out_next.out_command   = rec_rd_reg.command;
                    out_next.out_size      = rec_rd_reg.size;
                    out_next.out_exec_word = rec_rd_reg.exec;
                    out_next.out_byte      = (rec_rd_reg.size == '0) ? 8'd0 : pay_rd_reg;
                    out_next.last          = stream_last;
                    if (!stream_last)
                    begin
                        // Fetch the following byte while this one goes out
                        rd_en    = 1'b1;
                        rd_off   = cnt_inc[dlcrq_pkg::OFF_W-1:0];
                        cnt_next = cnt_inc;
                    end
                end
            end

            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlcrq_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    // Record memory
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            rec_mem[op.slot] <= op.hdr;
        end
        if (rd_en)
        begin
            rec_rd_reg <= rec_mem[rd_slot];
        end
    end

    // Payload memory
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[wr_addr] <= op.pay_byte;
        end
        if (rd_en)
        begin
            pay_rd_reg <= pay_mem[rd_addr];
        end
    end

    // A new op is taken only between fetch streams
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == dlcrq_pkg::BK_IDLE)
        else $error("op popped while streaming a fetch");

    // The final byte of a stream returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlcrq_pkg::BK_STREAM && load && out_next.last)
        |=> state_reg == dlcrq_pkg::BK_IDLE)
        else $error("stream did not end after last result");

    // A fetch pop always enters the streaming state
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && op.kind == dlcrq_pkg::OP_FETCH) |=> state_reg == dlcrq_pkg::BK_STREAM)
        else $error("fetch op did not start a stream");

    // Streaming never runs past the stored size
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlcrq_pkg::BK_STREAM && rec_rd_reg.size != '0)
        |-> cnt_reg < rec_rd_reg.size)
        else $error("stream byte index beyond record size");

endmodule

`default_nettype wire
